// File: hdl/riscv_instruction_encoder_top_macros.svh
// assertion macros shared by the encoder modules
`ifndef RISCV_INSTRUCTION_ENCODER_TOP_MACROS_SVH
`define RISCV_INSTRUCTION_ENCODER_TOP_MACROS_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define RVENC_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk_i, off during reset
`define RVENC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/rvenc_pkg.sv
// shared types, constants and field encoders for the instruction encoder
package rvenc_pkg;

  localparam int CODE_WORDS = 1024;
  localparam int CODE_AW    = $clog2(CODE_WORDS);
  localparam int FILL_W     = 13;
  localparam logic [FILL_W-1:0] CAP_RESET = 13'd4096;

  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_JAL    = 7'h6F;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_OPIMM  = 7'h13;
  localparam logic [6:0] OPC_OP     = 7'h33;

  localparam logic [6:0]  F7_ALT    = 7'h20;
  localparam logic [6:0]  F7_MULDIV = 7'h01;
  localparam logic [11:0] SRAI_MARK = 12'h400;
  localparam logic [31:0] LI_ROUND  = 32'h800;
  localparam logic [2:0]  F3_DOUBLE = 3'd3;
  localparam logic [4:0]  REG_RA    = 5'd1;
  localparam logic [4:0]  REG_ZERO  = 5'd0;

  typedef enum logic [5:0] {
    OP_ADD     = 6'd0,
    OP_SUB     = 6'd1,
    OP_MUL     = 6'd2,
    OP_DIV     = 6'd3,
    OP_REM     = 6'd4,
    OP_AND     = 6'd5,
    OP_OR      = 6'd6,
    OP_XOR     = 6'd7,
    OP_SLL     = 6'd8,
    OP_SRL     = 6'd9,
    OP_SRA     = 6'd10,
    OP_ADDI    = 6'd11,
    OP_ORI     = 6'd12,
    OP_XORI    = 6'd13,
    OP_ANDI    = 6'd14,
    OP_SLLI    = 6'd15,
    OP_SRLI    = 6'd16,
    OP_SRAI    = 6'd17,
    OP_LD      = 6'd18,
    OP_SD      = 6'd19,
    OP_BEQ     = 6'd20,
    OP_BNE     = 6'd21,
    OP_BLT     = 6'd22,
    OP_BGE     = 6'd23,
    OP_JAL     = 6'd24,
    OP_JALR    = 6'd25,
    OP_RET     = 6'd26,
    OP_LUI     = 6'd27,
    OP_LI      = 6'd28,
    OP_MV      = 6'd29,
    OP_RAW     = 6'd30,
    OP_PATCH   = 6'd31,
    OP_RESTART = 6'd32
  } op_e;

  typedef enum logic [1:0] {
    CMD_EMIT    = 2'd0,
    CMD_PATCH   = 2'd1,
    CMD_RESTART = 2'd2
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e   kind;
    logic [31:0] word0;
    logic [31:0] word1;
    logic        two;
    logic [11:0] site;
    logic [11:0] target;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  function automatic logic [31:0] enc_r(input logic [6:0] f7, input logic [4:0] rs2,
                                        input logic [4:0] rs1, input logic [2:0] f3,
                                        input logic [4:0] rd, input logic [6:0] opc);
    return {f7, rs2, rs1, f3, rd, opc};
  endfunction

  function automatic logic [31:0] enc_i(input logic [11:0] imm, input logic [4:0] rs1,
                                        input logic [2:0] f3, input logic [4:0] rd,
                                        input logic [6:0] opc);
    return {imm, rs1, f3, rd, opc};
  endfunction

  function automatic logic [31:0] enc_s(input logic [11:0] imm, input logic [4:0] rs2,
                                        input logic [4:0] rs1, input logic [2:0] f3,
                                        input logic [6:0] opc);
    return {imm[11:5], rs2, rs1, f3, imm[4:0], opc};
  endfunction

  function automatic logic [31:0] enc_b(input logic [12:0] imm, input logic [4:0] rs2,
                                        input logic [4:0] rs1, input logic [2:0] f3);
    return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OPC_BRANCH};
  endfunction

  function automatic logic [31:0] enc_j(input logic [20:0] imm, input logic [4:0] rd);
    return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OPC_JAL};
  endfunction

  function automatic logic [6:0] r_f7(input op_e op);
    logic [6:0] f7;
    unique case (op)
      OP_SUB, OP_SRA:         f7 = F7_ALT;
      OP_MUL, OP_DIV, OP_REM: f7 = F7_MULDIV;
      default:                f7 = 7'd0;
    endcase
    return f7;
  endfunction

  function automatic logic [2:0] r_f3(input op_e op);
    logic [2:0] f3;
    unique case (op)
      OP_DIV, OP_XOR: f3 = 3'd4;
      OP_REM, OP_OR:  f3 = 3'd6;
      OP_AND:         f3 = 3'd7;
      OP_SLL:         f3 = 3'd1;
      OP_SRL, OP_SRA: f3 = 3'd5;
      default:        f3 = 3'd0;
    endcase
    return f3;
  endfunction

  function automatic logic [2:0] i_f3(input op_e op);
    logic [2:0] f3;
    unique case (op)
      OP_ORI:           f3 = 3'd6;
      OP_XORI:          f3 = 3'd4;
      OP_ANDI:          f3 = 3'd7;
      OP_SLLI:          f3 = 3'd1;
      OP_SRLI, OP_SRAI: f3 = 3'd5;
      default:          f3 = 3'd0;
    endcase
    return f3;
  endfunction

  function automatic logic [2:0] b_f3(input op_e op);
    logic [2:0] f3;
    unique case (op)
      OP_BNE:  f3 = 3'd1;
      OP_BLT:  f3 = 3'd4;
      OP_BGE:  f3 = 3'd5;
      default: f3 = 3'd0;
    endcase
    return f3;
  endfunction

endpackage

// File: hdl/rvenc_front.sv
// front end: classifies a request and builds its machine words
module rvenc_front (
  input  logic                take_i,
  input  logic [5:0]          op_i,
  input  logic [4:0]          rd_i,
  input  logic [4:0]          rs1_i,
  input  logic [4:0]          rs2_i,
  input  logic signed [31:0]  imm_i,
  input  logic [11:0]         site_i,
  input  logic [11:0]         target_i,
  output logic                push_o,
  output rvenc_pkg::cmd_t     cmd_o
);
  import rvenc_pkg::*;

  logic        known;
  logic [31:0] imm_u;
  logic [31:0] li_sum;
  logic [19:0] li_hi;
  logic [11:0] li_lo;
  logic [11:0] sh_imm;
  op_e         op;

  assign op     = op_e'(op_i);
  assign imm_u  = imm_i;
  assign li_sum = imm_u + LI_ROUND;
  assign li_hi  = li_sum[31:12];
  assign li_lo  = imm_u[11:0];

  always_comb begin
    sh_imm = {6'd0, imm_u[5:0]};
    if (op_i == OP_SRAI) begin
      sh_imm = sh_imm | SRAI_MARK;
    end
  end

  always_comb begin
    known         = 1'b1;
    cmd_o.kind    = CMD_EMIT;
    cmd_o.word0   = 32'd0;
    cmd_o.word1   = 32'd0;
    cmd_o.two     = 1'b0;
    cmd_o.site    = site_i;
    cmd_o.target  = target_i;
    priority if (op_i <= OP_SRA) begin
      cmd_o.word0 = enc_r(r_f7(op), rs2_i, rs1_i, r_f3(op), rd_i, OPC_OP);
    end else if (op_i <= OP_ANDI) begin
      cmd_o.word0 = enc_i(imm_u[11:0], rs1_i, i_f3(op), rd_i, OPC_OPIMM);
    end else if (op_i <= OP_SRAI) begin
      cmd_o.word0 = enc_i(sh_imm, rs1_i, i_f3(op), rd_i, OPC_OPIMM);
    end else if (op_i <= OP_SD) begin
      if (op_i == OP_LD) begin
        cmd_o.word0 = enc_i(imm_u[11:0], rs1_i, F3_DOUBLE, rd_i, OPC_LOAD);
      end else begin
        cmd_o.word0 = enc_s(imm_u[11:0], rs2_i, rs1_i, F3_DOUBLE, OPC_STORE);
      end
    end else if (op_i <= OP_BGE) begin
      cmd_o.word0 = enc_b(imm_u[12:0], rs2_i, rs1_i, b_f3(op));
    end else begin
      unique case (op_i)
        OP_JAL:  cmd_o.word0 = enc_j(imm_u[20:0], rd_i);
        OP_JALR: cmd_o.word0 = enc_i(imm_u[11:0], rs1_i, 3'd0, rd_i, OPC_JALR);
        OP_RET:  cmd_o.word0 = enc_i(12'd0, REG_RA, 3'd0, REG_ZERO, OPC_JALR);
        OP_LUI:  cmd_o.word0 = {imm_u[19:0], rd_i, OPC_LUI};
        OP_LI: begin
          if (li_hi != 20'd0) begin
            cmd_o.word0 = {li_hi, rd_i, OPC_LUI};
            cmd_o.word1 = enc_i(li_lo, rd_i, 3'd0, rd_i, OPC_OPIMM);
            cmd_o.two   = (li_lo != 12'd0);
          end else begin
            cmd_o.word0 = enc_i(li_lo, REG_ZERO, 3'd0, rd_i, OPC_OPIMM);
          end
        end
        OP_MV:      cmd_o.word0 = enc_i(12'd0, rs1_i, 3'd0, rd_i, OPC_OPIMM);
        OP_RAW:     cmd_o.word0 = imm_u;
        OP_PATCH:   cmd_o.kind  = CMD_PATCH;
        OP_RESTART: cmd_o.kind  = CMD_RESTART;
        default:    known       = 1'b0;
      endcase
    end
  end

  assign push_o = take_i && known;

endmodule

// File: hdl/rvenc_queue.sv
// two-entry command queue between front end and back end
module rvenc_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  rvenc_pkg::cmd_t       cmd_i,
  input  logic                  pop_i,
  output rvenc_pkg::cmd_t       head_o,
  output rvenc_pkg::q_status_t  status_o
);
  import rvenc_pkg::*;

  cmd_t       slot_q [2];
  logic       wptr_q, wptr_d;
  logic       rptr_q, rptr_d;
  logic [1:0] count_q, count_d;
  logic       do_push, do_pop;

  assign status_o.empty = (count_q == 2'd0);
  assign status_o.full  = (count_q == 2'd2);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign head_o         = slot_q[rptr_q];

  always_comb begin
    wptr_d  = wptr_q ^ do_push;
    rptr_d  = rptr_q ^ do_pop;
    count_d = count_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= cmd_i;
    end
  end

endmodule

// File: hdl/rvenc_back.sv
// back end: code memory, fill position, patch and result registers
`include "riscv_instruction_encoder_top_macros.svh"

module rvenc_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [rvenc_pkg::FILL_W-1:0] cfg_wdata_i,
  input  rvenc_pkg::cmd_t              head_i,
  input  rvenc_pkg::q_status_t         status_i,
  output logic                         pop_o,
  output logic                         done_o,
  output logic [31:0]                  word_o,
  output logic [11:0]                  byte_addr_o,
  output logic                         stored_o,
  output logic                         dropped_o,
  output logic [rvenc_pkg::FILL_W-1:0] fill_bytes_o,
  output logic                         last_o
);
  import rvenc_pkg::*;

  localparam int MaxBytes = CODE_WORDS * 4;

  typedef enum logic [2:0] {
    ST_IDLE     = 3'b001,
    ST_WORD2    = 3'b010,
    ST_PATCH_RD = 3'b100
  } state_e;

  state_e              state_q, state_d;
  logic [FILL_W-1:0]   fill_q, fill_d;
  logic [FILL_W-1:0]   cap_q;
  logic [FILL_W-1:0]   lim;
  logic [31:0]         word1_q, word1_d;
  logic [11:0]         site_q, site_d;
  logic [11:0]         target_q, target_d;
  logic                done_q, done_d;
  logic [31:0]         word_q, word_d;
  logic [11:0]         addr_q, addr_d;
  logic                stored_q, stored_d;
  logic                dropped_q, dropped_d;
  logic                last_q, last_d;

  logic [31:0]         code_mem [CODE_WORDS];
  logic [31:0]         rdata_q;
  logic [CODE_AW-1:0]  raddr;
  logic                we;
  logic [CODE_AW-1:0]  waddr;
  logic [31:0]         wdata;

  logic                emit_req;
  logic [31:0]         emit_word;
  logic                emit_last;
  logic                room;
  logic                site_bad;
  logic [20:0]         off;

  always_comb begin
    if (int'(cap_q) < MaxBytes) begin
      lim = cap_q;
    end else begin
      lim = FILL_W'(MaxBytes);
    end
  end

  assign room     = ({1'b0, fill_q} + (FILL_W+1)'(4)) <= {1'b0, lim};
  assign site_bad = (head_i.site[1:0] != 2'b00) ||
                    (({2'b00, head_i.site} + (FILL_W+1)'(4)) > {1'b0, fill_q});
  assign off      = 21'(target_q) - 21'(site_q);
  assign raddr    = head_i.site[CODE_AW+1:2];
  assign pop_o    = (state_q == ST_IDLE) && !status_i.empty;

  always_comb begin
    state_d   = state_q;
    fill_d    = fill_q;
    word1_d   = word1_q;
    site_d    = site_q;
    target_d  = target_q;
    done_d    = 1'b0;
    word_d    = word_q;
    addr_d    = addr_q;
    stored_d  = 1'b0;
    dropped_d = 1'b0;
    last_d    = 1'b1;
    we        = 1'b0;
    waddr     = fill_q[CODE_AW+1:2];
    wdata     = 32'd0;
    emit_req  = 1'b0;
    emit_word = head_i.word0;
    emit_last = 1'b1;

    unique case (state_q)
      ST_IDLE: begin
        if (pop_o) begin
          unique case (head_i.kind)
            CMD_EMIT: begin
              emit_req  = 1'b1;
              emit_last = !head_i.two;
              word1_d   = head_i.word1;
              if (head_i.two) begin
                state_d = ST_WORD2;
              end
            end
            CMD_PATCH: begin
              if (site_bad) begin
                done_d = 1'b1;
                word_d = 32'd0;
                addr_d = 12'd0;
              end else begin
                site_d   = head_i.site;
                target_d = head_i.target;
                state_d  = ST_PATCH_RD;
              end
            end
            CMD_RESTART: begin
              done_d = 1'b1;
              word_d = 32'd0;
              addr_d = 12'd0;
              fill_d = '0;
            end
            default: ;
          endcase
        end
      end
      ST_WORD2: begin
        emit_req  = 1'b1;
        emit_word = word1_q;
        state_d   = ST_IDLE;
      end
      ST_PATCH_RD: begin
        done_d  = 1'b1;
        addr_d  = site_q;
        waddr   = site_q[CODE_AW+1:2];
        state_d = ST_IDLE;
        priority if (rdata_q[6:0] == OPC_BRANCH) begin
          wdata    = enc_b(off[12:0], rdata_q[24:20], rdata_q[19:15], rdata_q[14:12]);
          we       = 1'b1;
          stored_d = 1'b1;
          word_d   = wdata;
        end else if (rdata_q[6:0] == OPC_JAL) begin
          wdata    = enc_j(off, rdata_q[11:7]);
          we       = 1'b1;
          stored_d = 1'b1;
          word_d   = wdata;
        end else begin
          word_d = rdata_q;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (emit_req) begin
      done_d = 1'b1;
      word_d = emit_word;
      last_d = emit_last;
      if (room) begin
        we       = 1'b1;
        wdata    = emit_word;
        stored_d = 1'b1;
        addr_d   = fill_q[11:0];
        fill_d   = fill_q + FILL_W'(4);
      end else begin
        dropped_d = 1'b1;
        addr_d    = 12'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fill_q  <= '0;
      cap_q   <= CAP_RESET;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      done_q  <= done_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    word1_q   <= word1_d;
    site_q    <= site_d;
    target_q  <= target_d;
    word_q    <= word_d;
    addr_q    <= addr_d;
    stored_q  <= stored_d;
    dropped_q <= dropped_d;
    last_q    <= last_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      code_mem[waddr] <= wdata;
    end
    rdata_q <= code_mem[raddr];
  end

  assign done_o       = done_q;
  assign word_o       = word_q;
  assign byte_addr_o  = addr_q;
  assign stored_o     = stored_q;
  assign dropped_o    = dropped_q;
  assign fill_bytes_o = fill_q;
  assign last_o       = last_q;

  `RVENC_ASSERT_NOW(a_fill_aligned, 1'b1, fill_q[1:0] == 2'b00, "fill position not word aligned")
  `RVENC_ASSERT_NOW(a_store_xor_drop, done_q, !(stored_q && dropped_q), "stored and dropped together")
  `RVENC_ASSERT_NOW(a_word2_after_first, state_q == ST_WORD2, done_q && !last_q, "second word without first")
  `RVENC_ASSERT_NOW(a_drop_keeps_fill, done_q && dropped_q, fill_q == $past(fill_q), "drop moved fill")
  `RVENC_ASSERT_NEXT(a_patch_one_result, state_q == ST_PATCH_RD, done_q && last_q, "patch gave no result")

endmodule

// File: hdl/riscv_instruction_encoder_top.sv
// top level of the rv64im instruction encoder
//
//   channel   signals                                        handshake
//   request   op_i rd_i rs1_i rs2_i imm_i site_i target_i    start / busy
//   result    word_o byte_addr_o stored_o dropped_o          done_o strobe
//             fill_bytes_o last_o
//   config    cfg_wdata_i                                    cfg_we_i
//
// a request is taken when start is high and busy is low; busy rises while the
// two-entry command queue is full. the back end turns each queued command into
// one result per word, two for a two-word li; a valid patch site passes a read
// state as the code memory read is registered; the back end pops only when
// idle. reset clears fill and the queue and sets capacity to 4096; code
// memory is not cleared. results are single-cycle, unstallable strobes.
module riscv_instruction_encoder_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [5:0]                   op_i,
  input  logic [4:0]                   rd_i,
  input  logic [4:0]                   rs1_i,
  input  logic [4:0]                   rs2_i,
  input  logic signed [31:0]           imm_i,
  input  logic [11:0]                  site_i,
  input  logic [11:0]                  target_i,
  input  logic                         cfg_we_i,
  input  logic [rvenc_pkg::FILL_W-1:0] cfg_wdata_i,
  output logic                         done_o,
  output logic [31:0]                  word_o,
  output logic [11:0]                  byte_addr_o,
  output logic                         stored_o,
  output logic                         dropped_o,
  output logic [rvenc_pkg::FILL_W-1:0] fill_bytes_o,
  output logic                         last_o
);
  import rvenc_pkg::*;

  logic      take;
  logic      push;
  logic      pop;
  cmd_t      cmd;
  cmd_t      head;
  q_status_t q_status;

  assign busy = q_status.full;
  assign take = start && !busy;

  rvenc_front u_front (
    .take_i   (take),
    .op_i     (op_i),
    .rd_i     (rd_i),
    .rs1_i    (rs1_i),
    .rs2_i    (rs2_i),
    .imm_i    (imm_i),
    .site_i   (site_i),
    .target_i (target_i),
    .push_o   (push),
    .cmd_o    (cmd)
  );

  rvenc_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .cmd_i    (cmd),
    .pop_i    (pop),
    .head_o   (head),
    .status_o (q_status)
  );

  rvenc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .head_i       (head),
    .status_i     (q_status),
    .pop_o        (pop),
    .done_o       (done_o),
    .word_o       (word_o),
    .byte_addr_o  (byte_addr_o),
    .stored_o     (stored_o),
    .dropped_o    (dropped_o),
    .fill_bytes_o (fill_bytes_o),
    .last_o       (last_o)
  );

endmodule
